[hdl/cbt_pkg.sv]
// shared types, constants and helpers for the csv byte tokenizer
// no dependencies

package cbt_pkg;

	localparam int unsigned ADDR_W = 4;

	localparam logic [7:0] QUOTE_BYTE = 8'h22;
	localparam logic [16:0] PAD_BYTES = 17'd2;

	localparam logic [7:0] COL_DELIM_RST = 8'd44;
	localparam logic [7:0] ROW_DELIM_RST = 8'd10;
	localparam logic [7:0] SLOT_SIZE_RST = 8'd16;
	localparam logic [7:0] COLUMNS_RST = 8'd8;

	typedef enum logic [1:0] {
		REG_COL_DELIM = 2'd0,
		REG_ROW_DELIM = 2'd1,
		REG_SLOT_SIZE = 2'd2,
		REG_COLUMNS   = 2'd3
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_ADDR
	} state_t;

	typedef struct packed {
		logic [7:0] column_delimiter;
		logic [7:0] row_delimiter;
		logic [7:0] slot_size;
		logic [7:0] columns_per_row;
	} cfg_t;

	typedef struct packed {
		logic accept;
		logic mul_en;
		logic load;
	} cmd_t;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       file_start;
	} text_t;

	typedef struct packed {
		logic        store_enable;
		logic [15:0] store_address;
		logic [7:0]  store_byte;
		logic        out_of_range;
		logic [15:0] rows_counted;
		logic [7:0]  first_row_columns;
		logic [15:0] slot_size_needed;
	} result_t;

	function automatic logic [7:0] sat_inc8(input logic [7:0] v);
		return (v == 8'hFF) ? v : v + 8'd1;
	endfunction

	function automatic logic [15:0] sat_inc16(input logic [15:0] v);
		return (v == 16'hFFFF) ? v : v + 16'd1;
	endfunction

endpackage

[hdl/cbt_stream_if.sv]
// valid/ready channel carrying one item per handshake
// depends on nothing; payload type is set where it is instantiated

interface cbt_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

[hdl/cbt_cfg_regs.sv]
// apb configuration registers: delimiters, slot size, columns per row
// depends on cbt_pkg

module cbt_cfg_regs (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [cbt_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready,
	output cbt_pkg::cfg_t              cfg
);

	cbt_pkg::cfg_t    cfg_q;
	cbt_pkg::reg_idx_t idx;
	logic             wr_en;

	assign pready = 1'b1;
	assign idx    = cbt_pkg::reg_idx_t'(paddr[3:2]);
	assign wr_en  = psel && penable && pwrite && pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.column_delimiter <= cbt_pkg::COL_DELIM_RST;
			cfg_q.row_delimiter    <= cbt_pkg::ROW_DELIM_RST;
			cfg_q.slot_size        <= cbt_pkg::SLOT_SIZE_RST;
			cfg_q.columns_per_row  <= cbt_pkg::COLUMNS_RST;
		end else if (wr_en) begin
			case (idx)
				cbt_pkg::REG_COL_DELIM: cfg_q.column_delimiter <= pwdata[7:0];
				cbt_pkg::REG_ROW_DELIM: cfg_q.row_delimiter    <= pwdata[7:0];
				cbt_pkg::REG_SLOT_SIZE: cfg_q.slot_size        <= pwdata[7:0];
				cbt_pkg::REG_COLUMNS:   cfg_q.columns_per_row  <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			cbt_pkg::REG_COL_DELIM: prdata = {24'd0, cfg_q.column_delimiter};
			cbt_pkg::REG_ROW_DELIM: prdata = {24'd0, cfg_q.row_delimiter};
			cbt_pkg::REG_SLOT_SIZE: prdata = {24'd0, cfg_q.slot_size};
			cbt_pkg::REG_COLUMNS:   prdata = {24'd0, cfg_q.columns_per_row};
			default:                prdata = 32'd0;
		endcase
	end

endmodule

[hdl/cbt_ctrl.sv]
// controller: sequences accept, multiply and address stages, owns the handshakes
// depends on cbt_pkg

module cbt_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          text_valid,
	output logic          text_ready,
	output logic          result_valid,
	input  logic          result_ready,
	output cbt_pkg::cmd_t cmd
);

	cbt_pkg::state_t state_q;
	cbt_pkg::state_t state_d;
	logic            out_valid_q;
	logic            out_free;

	assign out_free     = !out_valid_q || result_ready;
	assign result_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			cbt_pkg::ST_IDLE: if (text_valid) state_d = cbt_pkg::ST_MUL;
			cbt_pkg::ST_MUL:  state_d = cbt_pkg::ST_ADDR;
			cbt_pkg::ST_ADDR: if (out_free) state_d = cbt_pkg::ST_IDLE;
			default:          state_d = cbt_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		text_ready = 1'b0;
		cmd        = '0;
		case (state_q)
			cbt_pkg::ST_IDLE: begin
				text_ready = 1'b1;
				cmd.accept = text_valid;
			end
			cbt_pkg::ST_MUL:  cmd.mul_en = 1'b1;
			cbt_pkg::ST_ADDR: cmd.load = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= cbt_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_load_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> out_valid_q)
		else $error("result register loaded but not presented");

	a_accept_then_mul: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept |=> (state_q == cbt_pkg::ST_MUL) && !text_ready)
		else $error("accepted item did not start the multiply");

	a_mul_then_addr: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == cbt_pkg::ST_MUL) |=> (state_q == cbt_pkg::ST_ADDR))
		else $error("multiply stage not followed by address stage");

	a_stall_holds_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == cbt_pkg::ST_ADDR) && out_valid_q && !result_ready |-> !cmd.load)
		else $error("result register overwritten while stalled");

endmodule

[hdl/cbt_dpath.sv]
// datapath: tokenizer state, statistics, grid address multiply and range check
// depends on cbt_pkg

module cbt_dpath #(
	parameter int unsigned STORE_BYTES = 65536
) (
	input  logic             clk,
	input  logic             arst_n,
	input  cbt_pkg::cfg_t    cfg,
	input  cbt_pkg::cmd_t    cmd,
	input  cbt_pkg::text_t   text_in,
	output cbt_pkg::result_t result_out
);

	localparam logic [33:0] StoreLimit = 34'(STORE_BYTES);

	// tokenizer and statistics state
	logic        in_quotes_q;
	logic [7:0]  char_index_q;
	logic [7:0]  column_index_q;
	logic [15:0] row_index_q;
	logic [15:0] row_count_q;
	logic [7:0]  column_count_q;
	logic [15:0] entry_length_q;
	logic [15:0] longest_entry_q;

	// per item stage registers
	logic        data_s1;
	logic [7:0]  byte_s1;
	logic [15:0] row_s1;
	logic [7:0]  col_s1;
	logic [7:0]  ch_s1;
	logic [24:0] lin_s2;

	logic        out_en_q;
	logic [15:0] out_addr_q;
	logic [7:0]  out_byte_q;
	logic        out_oor_q;
	logic [15:0] out_rows_q;
	logic [7:0]  out_cols_q;
	logic [15:0] needed_q;

	logic [7:0]  slot_eff;
	logic [7:0]  cols_eff;

	logic        q_e;
	logic [7:0]  ch_e;
	logic [7:0]  col_e;
	logic [15:0] row_e;
	logic [15:0] rc_e;
	logic [7:0]  cc_e;
	logic [15:0] el_e;
	logic [15:0] le_e;

	logic        quote_n;
	logic        is_col;
	logic        is_row;
	logic [15:0] el_inc;
	logic [15:0] el_n;
	logic [15:0] le_n;
	logic [15:0] rc_n;
	logic [7:0]  cc_n;
	logic [7:0]  ch_w;
	logic [7:0]  col_w;
	logic [15:0] row_w;
	logic [7:0]  ch_n;
	logic [7:0]  col_n;
	logic [15:0] row_n;

	logic [24:0] lin_d;
	logic [33:0] addr_full;
	logic [16:0] needed_sum;

	assign slot_eff = (cfg.slot_size == 8'd0) ? 8'd1 : cfg.slot_size;
	assign cols_eff = (cfg.columns_per_row == 8'd0) ? 8'd1 : cfg.columns_per_row;

	// state seen by this item, reset to its start values on file start
	always_comb begin
		if (text_in.file_start) begin
			q_e   = 1'b0;
			ch_e  = 8'd0;
			col_e = 8'd0;
			row_e = 16'd0;
			rc_e  = 16'd1;
			cc_e  = 8'd1;
			el_e  = 16'd0;
			le_e  = 16'd0;
		end else begin
			q_e   = in_quotes_q;
			ch_e  = char_index_q;
			col_e = column_index_q;
			row_e = row_index_q;
			rc_e  = row_count_q;
			cc_e  = column_count_q;
			el_e  = entry_length_q;
			le_e  = longest_entry_q;
		end
	end

	always_comb begin
		quote_n = q_e ^ (text_in.text_byte == cbt_pkg::QUOTE_BYTE);
		is_col  = (text_in.text_byte == cfg.column_delimiter) && !quote_n;
		is_row  = (text_in.text_byte == cfg.row_delimiter) && !quote_n;

		// statistics
		el_inc = cbt_pkg::sat_inc16(el_e);
		cc_n   = (is_col && rc_e == 16'd1) ? cbt_pkg::sat_inc8(cc_e) : cc_e;
		rc_n   = is_row ? cbt_pkg::sat_inc16(rc_e) : rc_e;
		if (is_col || is_row) begin
			le_n = (el_inc > le_e) ? el_inc : le_e;
			el_n = 16'd0;
		end else begin
			le_n = le_e;
			el_n = el_inc;
		end

		// full slot wraps to the next cell
		ch_w  = ch_e;
		col_w = col_e;
		row_w = row_e;
		if (ch_e >= slot_eff) begin
			ch_w = 8'd0;
			if (col_e == cols_eff - 8'd1) begin
				col_w = 8'd0;
				row_w = cbt_pkg::sat_inc16(row_e);
			end else begin
				col_w = cbt_pkg::sat_inc8(col_e);
			end
		end

		// grid move or data write
		ch_n  = ch_w;
		col_n = col_w;
		row_n = row_w;
		if (is_col) begin
			ch_n  = 8'd0;
			col_n = cbt_pkg::sat_inc8(col_w);
		end else if (is_row) begin
			ch_n  = 8'd0;
			col_n = 8'd0;
			row_n = cbt_pkg::sat_inc16(row_w);
		end else begin
			ch_n = cbt_pkg::sat_inc8(ch_w);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_quotes_q     <= 1'b0;
			char_index_q    <= 8'd0;
			column_index_q  <= 8'd0;
			row_index_q     <= 16'd0;
			row_count_q     <= 16'd1;
			column_count_q  <= 8'd1;
			entry_length_q  <= 16'd0;
			longest_entry_q <= 16'd0;
		end else if (cmd.accept) begin
			in_quotes_q     <= quote_n;
			char_index_q    <= ch_n;
			column_index_q  <= col_n;
			row_index_q     <= row_n;
			row_count_q     <= rc_n;
			column_count_q  <= cc_n;
			entry_length_q  <= el_n;
			longest_entry_q <= le_n;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			data_s1 <= !is_col && !is_row;
			byte_s1 <= text_in.text_byte;
			row_s1  <= row_w;
			col_s1  <= col_w;
			ch_s1   <= ch_w;
		end
	end

	// row * columns + column
	assign lin_d = 25'(row_s1) * 25'(cols_eff) + 25'(col_s1);

	always_ff @(posedge clk) begin
		if (cmd.mul_en) begin
			lin_s2 <= lin_d;
		end
	end

	// slot * cell + char, then range check
	assign addr_full  = 34'(slot_eff) * 34'(lin_s2) + 34'(ch_s1);
	assign needed_sum = 17'(longest_entry_q) + cbt_pkg::PAD_BYTES;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_en_q   <= 1'b0;
			out_addr_q <= 16'd0;
			out_byte_q <= 8'd0;
			out_oor_q  <= 1'b0;
			out_rows_q <= 16'd1;
			out_cols_q <= 8'd1;
			needed_q   <= 16'd2;
		end else if (cmd.load) begin
			needed_q   <= needed_sum[16] ? 16'hFFFF : needed_sum[15:0];
			out_rows_q <= row_count_q;
			out_cols_q <= column_count_q;
			if (!data_s1) begin
				out_en_q   <= 1'b0;
				out_addr_q <= 16'd0;
				out_byte_q <= 8'd0;
				out_oor_q  <= 1'b0;
			end else if (addr_full >= StoreLimit) begin
				out_en_q   <= 1'b0;
				out_addr_q <= 16'd0;
				out_byte_q <= byte_s1;
				out_oor_q  <= 1'b1;
			end else begin
				out_en_q   <= 1'b1;
				out_addr_q <= addr_full[15:0];
				out_byte_q <= byte_s1;
				out_oor_q  <= 1'b0;
			end
		end
	end

	assign result_out.store_enable      = out_en_q;
	assign result_out.store_address     = out_addr_q;
	assign result_out.store_byte        = out_byte_q;
	assign result_out.out_of_range      = out_oor_q;
	assign result_out.rows_counted      = out_rows_q;
	assign result_out.first_row_columns = out_cols_q;
	assign result_out.slot_size_needed  = needed_q;

	a_write_xor_drop: assert property (@(posedge clk) disable iff (!arst_n)
		!(out_en_q && out_oor_q))
		else $error("item both written and flagged out of range");

	a_needed_floor: assert property (@(posedge clk) disable iff (!arst_n)
		needed_q >= 16'd2)
		else $error("slot size needed below padding");

endmodule

[hdl/csv_byte_tokenizer_to_grid_unit.sv]
// top level of the csv byte tokenizer: config registers, controller, datapath
// depends on cbt_pkg, cbt_stream_if, cbt_cfg_regs, cbt_ctrl, cbt_dpath

// Each accepted text byte yields exactly one result item. On its way to the
// result register an item passes the tokenizer state and statistics update,
// the row times columns multiply, then the slot-size multiply and the store
// range check. The next byte is accepted the cycle after the result register
// loads, so the block takes no new byte while the last one is still on its
// way; a waiting result does not block a new accept, only the load of the
// following result. Configuration registers sit at byte addresses 0, 4, 8
// and 12 and must be written only while idle.

module csv_byte_tokenizer_to_grid_unit #(
	parameter int unsigned STORE_BYTES = 65536
) (
	input  logic                       clk,
	input  logic                       arst_n,
	cbt_stream_if.sink                 text,
	cbt_stream_if.source               result,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [cbt_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready
);

	cbt_pkg::cfg_t    cfg;
	cbt_pkg::cmd_t    cmd;
	cbt_pkg::text_t   text_item;
	cbt_pkg::result_t result_item;

	assign text_item      = text.payload;
	assign result.payload = result_item;

	cbt_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	cbt_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.text_valid   (text.valid),
		.text_ready   (text.ready),
		.result_valid (result.valid),
		.result_ready (result.ready),
		.cmd          (cmd)
	);

	cbt_dpath #(
		.STORE_BYTES (STORE_BYTES)
	) u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.cmd        (cmd),
		.text_in    (text_item),
		.result_out (result_item)
	);

endmodule
